>>> design/pds_pkg.sv
// Package with shared constants and types for the periodic deadline scheduler.
`default_nettype none
package pds_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_W = 32;
    localparam int ID_W = 8;
    localparam int PERIOD_W = 16;
    localparam int ENTRY_W = TIME_W + ID_W + PERIOD_W;

    localparam logic [1:0] ST_SCHEDULED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DISPATCH = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_TICK = 1'b1;
endpackage
`default_nettype wire

>>> design/pds_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/periodic_deadline_scheduler.sv
// Top level of the periodic deadline scheduler: sequencer around the entry RAM.
// A word is taken at a rising edge with start high and busy low, and busy then stays high
// until the block is ready for the next word. Every result is registered and shown on
// valid for exactly one cycle. The receiver cannot stall, so nothing here waits on it.
// A schedule word holds busy through the schedule state, and its result is registered and
// shown in the cycle after that state. A tick word runs one scan of the entry RAM through
// its single read port for each dispatched task, plus one final scan that finds nothing
// left. A scan issues a read for each stored entry and compares each returned entry.
// Each scan is followed by an evaluate state, and each dispatch adds a write-back state.
// Each dispatch word is held back until the next scan shows whether it is the last one.
// The final word appears in the first cycle in which busy is low. Per-tick "already
// dispatched" flags are kept in flip-flops, one per queue slot.
`default_nettype none
module periodic_deadline_scheduler
    import pds_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                action,
    input  wire logic [ID_W-1:0]     task_id,
    input  wire logic [PERIOD_W-1:0] period,
    output logic                     valid,
    output logic      [ID_W-1:0]     due_task,
    output logic      [1:0]          status,
    output logic                     last
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_SCHED = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [CW-1:0]        idx_reg, idx_next;      // address issued
    logic [AW-1:0]        ridx_reg, ridx_next;    // address of data on rdata
    logic                 rvalid_reg, rvalid_next;
    logic [QUEUE_DEPTH-1:0] done_reg, done_next;
    logic                 found_reg, found_next;
    logic                 any_reg, any_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]    best_age_reg, best_age_next;
    logic [ID_W-1:0]      best_id_reg, best_id_next;
    logic [PERIOD_W-1:0]  best_per_reg, best_per_next;
    logic [ID_W-1:0]      sid_reg, sid_next;
    logic [PERIOD_W-1:0]  sper_reg, sper_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [ENTRY_W-1:0]   wdata, rdata;
    logic [AW-1:0]        raddr;

    logic [TIME_W-1:0]    r_due, r_age;
    logic [ID_W-1:0]      r_id;
    logic [PERIOD_W-1:0]  r_per;
    logic                 r_due_ok, r_better;

    logic                 seq_v;
    logic [ID_W-1:0]      seq_id;
    logic [1:0]           seq_st;
    logic                 seq_l;

    pds_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign r_due = rdata[ENTRY_W-1 -: TIME_W];
    assign r_id  = rdata[PERIOD_W +: ID_W];
    assign r_per = rdata[PERIOD_W-1:0];
    assign r_age = time_reg - r_due;
    assign r_due_ok = !r_age[TIME_W-1] && !done_reg[ridx_reg];
    assign r_better = !found_reg || (r_age > best_age_reg)
        || (r_age == best_age_reg && r_id < best_id_reg);
    assign raddr = idx_reg[AW-1:0];
    assign busy = (state_reg != S_IDLE);

    // Sequencer: schedule writes one entry unless the queue is full; tick repeats min-search scans.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        time_next = time_reg;
        idx_next = idx_reg;
        ridx_next = ridx_reg;
        rvalid_next = 1'b0;
        done_next = done_reg;
        found_next = found_reg;
        any_next = any_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        best_id_next = best_id_reg;
        best_per_next = best_per_reg;
        sid_next = sid_reg;
        sper_next = sper_reg;
        we = 1'b0;
        waddr = best_idx_reg;
        wdata = {time_reg + TIME_W'(best_per_reg), best_id_reg, best_per_reg};
        seq_v = 1'b0;
        seq_id = best_id_reg;
        seq_st = ST_DISPATCH;
        seq_l = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sid_next = task_id;
                    sper_next = period;
                    if (action == ACT_SCHEDULE)
                    begin
                        state_next = S_SCHED;
                    end
                    else
                    begin
                        time_next = time_reg + 1'b1;
                        done_next = '0;
                        any_next = 1'b0;
                        found_next = 1'b0;
                        idx_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCHED:
            begin
                seq_v = 1'b1;
                seq_id = sid_reg;
                seq_l = 1'b1;
                if (count_reg >= CW'(QUEUE_DEPTH))
                begin
                    seq_st = ST_FULL;
                end
                else
                begin
                    seq_st = ST_SCHEDULED;
                    we = 1'b1;
                    waddr = count_reg[AW-1:0];
                    wdata = {time_reg + TIME_W'(sper_reg), sid_reg, sper_reg};
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // Issue reads for entries below the count; compare returned data.
                if (rvalid_reg && r_due_ok && r_better)
                begin
                    found_next = 1'b1;
                    best_idx_next = ridx_reg;
                    best_age_next = r_age;
                    best_id_next = r_id;
                    best_per_next = r_per;
                end
                if (idx_reg < count_reg)
                begin
                    rvalid_next = 1'b1;
                    ridx_next = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rvalid_reg)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (found_reg)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    if (!any_reg)
                    begin
                        seq_v = 1'b1;
                        seq_id = '0;
                        seq_st = ST_NONE;
                        seq_l = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_WB:
            begin
                // Dispatch and put the task back; flag it for this tick.
                we = 1'b1;
                seq_v = 1'b1;
                done_next[best_idx_reg] = 1'b1;
                any_next = 1'b1;
                found_next = 1'b0;
                idx_next = '0;
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Because "last" must be known at dispatch, a trailing scan may find nothing;
    // the dispatch word is therefore delayed one scan and flagged when known.
    logic                pend_reg, pend_next;
    logic [ID_W-1:0]     pid_reg, pid_next;
    logic                out_v;
    logic [ID_W-1:0]     out_id;
    logic [1:0]          out_st;
    logic                out_l;

    always_comb
    begin
        pend_next = pend_reg;
        pid_next = pid_reg;
        out_v = 1'b0;
        out_id = seq_id;
        out_st = seq_st;
        out_l = seq_l;
        if (seq_v && seq_st != ST_DISPATCH)
        begin
            out_v = 1'b1;
        end
        if (state_reg == S_WB)
        begin
            if (pend_reg)
            begin
                out_v = 1'b1;
                out_id = pid_reg;
                out_st = ST_DISPATCH;
                out_l = 1'b0;
            end
            pend_next = 1'b1;
            pid_next = best_id_reg;
        end
        else if (state_reg == S_EVAL && !found_reg && pend_reg)
        begin
            out_v = 1'b1;
            out_id = pid_reg;
            out_st = ST_DISPATCH;
            out_l = 1'b1;
            pend_next = 1'b0;
        end
    end

    // Result registers and control state.
    logic               v_reg;
    logic [ID_W-1:0]    id_reg;
    logic [1:0]         st_reg;
    logic               l_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            time_reg <= '0;
            idx_reg <= '0;
            rvalid_reg <= 1'b0;
            done_reg <= '0;
            found_reg <= 1'b0;
            any_reg <= 1'b0;
            pend_reg <= 1'b0;
            v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg <= time_next;
            idx_reg <= idx_next;
            rvalid_reg <= rvalid_next;
            done_reg <= done_next;
            found_reg <= found_next;
            any_reg <= any_next;
            pend_reg <= pend_next;
            v_reg <= out_v;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        best_id_reg <= best_id_next;
        best_per_reg <= best_per_next;
        sid_reg <= sid_next;
        sper_reg <= sper_next;
        pid_reg <= pid_next;
        id_reg <= out_id;
        st_reg <= out_st;
        l_reg <= out_l;
    end

    // Registered result ports.
    assign valid = v_reg;
    assign due_task = id_reg;
    assign status = st_reg;
    assign last = l_reg;
endmodule
`default_nettype wire

>>> design/pds_checker.sv
// Port-level checker for the periodic deadline scheduler, bound to the top level.
`default_nettype none
module pds_checker
    import pds_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            valid,
    input wire logic [ID_W-1:0] due_task,
    input wire logic [1:0]      status,
    input wire logic            last
);
    // A word taken when idle makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    // Nothing-due results report task zero and are marked last.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == ST_NONE |-> due_task == '0 && last)
        else $error("nothing-due result malformed");
    // Schedule outcomes are single results.
    a_sched_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == ST_SCHEDULED || status == ST_FULL) |-> last)
        else $error("schedule result not last");
endmodule

bind periodic_deadline_scheduler pds_checker u_pds_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .valid(valid),
    .due_task(due_task), .status(status), .last(last)
);
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the periodic deadline scheduler.
module tb_top;
    import pds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ID_W-1:0] task_id;
        logic [1:0]      status;
        logic            last;
    } dispatch_word_t;

    typedef struct {
        logic [TIME_W-1:0]   due;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
    } slot_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;
    logic                valid;
    logic [ID_W-1:0]     due_task;
    logic [1:0]          status;
    logic                last;

    // Predictor state.
    slot_t             slots[DEPTH];
    int                slot_count;
    logic [TIME_W-1:0] now_ticks;
    dispatch_word_t    expected_words[$];
    int                error_count;
    int                cycle_count;
    bit                calm;

    periodic_deadline_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .task_id(task_id), .period(period),
        .valid(valid), .due_task(due_task), .status(status), .last(last)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Works out the words that one accepted item will produce.
    task automatic predict_dispatch(input logic act, input logic [ID_W-1:0] id,
                                    input logic [PERIOD_W-1:0] per);
        bit                pending[DEPTH];
        int                best;
        logic [TIME_W-1:0] best_age;
        logic [TIME_W-1:0] age;
        int                n;
        if (act == ACT_SCHEDULE)
        begin
            if (slot_count >= DEPTH)
                expected_words.push_back('{id, ST_FULL, 1'b1});
            else
            begin
                slots[slot_count] = '{now_ticks + per, id, per};
                slot_count++;
                expected_words.push_back('{id, ST_SCHEDULED, 1'b1});
            end
            return;
        end
        now_ticks = now_ticks + 1;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            pending[i] = (i < slot_count) && ((now_ticks - slots[i].due) < 32'h8000_0000);
        forever
        begin
            best = -1;
            best_age = 0;
            for (int i = 0; i < slot_count; i++)
            begin
                if (!pending[i])
                    continue;
                age = now_ticks - slots[i].due;
                if (best < 0 || age > best_age ||
                    (age == best_age && slots[i].id < slots[best].id))
                begin
                    best = i;
                    best_age = age;
                end
            end
            if (best < 0)
                break;
            pending[best] = 1'b0;
            slots[best].due = now_ticks + slots[best].period;
            expected_words.push_back('{slots[best].id, ST_DISPATCH, 1'b0});
            n++;
        end
        if (n == 0)
            expected_words.push_back('{'0, ST_NONE, 1'b1});
        else
            expected_words[$].last = 1'b1;
    endtask

    // Sends one word, with a random gap unless in a calm stretch.
    task automatic send_word(input logic act, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] per);
        while (!calm && $urandom_range(99) < 18)
            @(posedge clk);
        // Wait until the block is idle, then present the word at a rising edge.
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        start <= 1'b1;
        action <= act;
        task_id <= id;
        period <= per;
        @(posedge clk);
        predict_dispatch(act, id, per);
        start <= 1'b0;
        action <= 1'($urandom_range(1));
        task_id <= ID_W'($urandom);
        period <= PERIOD_W'($urandom);
    endtask

    // Checks each result word against the oldest expectation.
    always @(posedge clk)
    begin
        dispatch_word_t want;
        if (rst_n && valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: due_task %0d status %0d", due_task, status);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (due_task !== want.task_id)
                begin
                    $error("due_task expected %0d actual %0d", want.task_id, due_task);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic tick_word();
        send_word(ACT_TICK, ID_W'($urandom), PERIOD_W'($urandom));
    endtask

    // Extremes, duplicates, ties, queue full and an empty tick.
    task automatic test_directed();
        tick_word();
        send_word(ACT_SCHEDULE, 8'd255, 16'd1);
        send_word(ACT_SCHEDULE, 8'd0, 16'd1);
        send_word(ACT_SCHEDULE, 8'd7, 16'd1);
        send_word(ACT_SCHEDULE, 8'd7, 16'd2);
        send_word(ACT_SCHEDULE, 8'hAA, 16'hFFFF);
        send_word(ACT_SCHEDULE, 8'h55, 16'h8000);
        tick_word();
        tick_word();
        tick_word();
        for (int i = 0; i < 12; i++)
            send_word(ACT_SCHEDULE, 8'(i + 16), 16'(1 + (i % 3)));
        tick_word();
        tick_word();
    endtask

    // Random ticks and schedules; short periods so tasks fire often.
    task automatic test_random();
        logic [PERIOD_W-1:0] per;
        for (int i = 0; i < 106; i++)
        begin
            calm = (i >= 40 && i < 70);
            if ($urandom_range(99) < 60)
                tick_word();
            else
            begin
                case ($urandom_range(9))
                    0: per = PERIOD_W'($urandom);
                    1: per = 16'hFFFF;
                    default: per = 16'($urandom_range(1, 6));
                endcase
                send_word(ACT_SCHEDULE, ID_W'($urandom), per);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        start = 1'b0;
        action = 1'b0;
        task_id = '0;
        period = '0;
        slot_count = 0;
        now_ticks = '0;
        error_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_cycles = 0;
        while (expected_words.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
